### src/rpy_pkg.sv
// package: payload types, constants and cordic angle table for the rpy rotation unit
`timescale 1ns / 1ps
package rpy_pkg;

	localparam int CordicStagesDefault = 16;
	localparam int AngTabLen = 24;
	localparam logic signed [33:0] GainQ30 = 34'sd652032875;
	localparam logic signed [15:0] Q14One = 16'sd16384;

	typedef struct packed {
		logic signed [15:0] roll_angle;
		logic signed [15:0] pitch_angle;
		logic signed [15:0] yaw_angle;
	} rpy_in_t;

	typedef struct packed {
		logic signed [15:0] m00;
		logic signed [15:0] m01;
		logic signed [15:0] m02;
		logic signed [15:0] m10;
		logic signed [15:0] m11;
		logic signed [15:0] m12;
		logic signed [15:0] m20;
		logic signed [15:0] m21;
		logic signed [15:0] m22;
	} rpy_out_t;

	// atan(2^-i) in units of 2^-32 turn
	function automatic logic [31:0] atan_turns(input logic [4:0] i);
		logic [31:0] r;
		unique case (i)
			5'd0: r = 32'h20000000;
			5'd1: r = 32'h12E4051D;
			5'd2: r = 32'h09FB385B;
			5'd3: r = 32'h051111D4;
			5'd4: r = 32'h028B0D43;
			5'd5: r = 32'h0145D7E1;
			5'd6: r = 32'h00A2F61E;
			5'd7: r = 32'h00517C55;
			5'd8: r = 32'h0028BE53;
			5'd9: r = 32'h00145F2E;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2F9;
			5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A2F;
			5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3;
			5'd23: r = 32'h00000051;
			default: r = 32'h0;
		endcase
		return r;
	endfunction

	// clamp a rounded value to [-1, +1] in q1.14
	function automatic logic signed [15:0] clamp_q14(input logic signed [33:0] v);
		logic signed [15:0] r;
		if (v > 34'sd16384) begin
			r = Q14One;
		end else if (v < -34'sd16384) begin
			r = -Q14One;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

### src/rpy_cordic.sv
// module: pipelined rotation-mode cordic, one stage per register, quadrant fold at the end
`timescale 1ns / 1ps
module rpy_cordic #(
	parameter int CORDIC_STAGES = rpy_pkg::CordicStagesDefault
) (
	input  logic               clk,
	input  logic               en,
	input  logic signed [15:0] angle,
	output logic signed [15:0] sin_q14,
	output logic signed [15:0] cos_q14
);
	import rpy_pkg::*;

	localparam int N = (CORDIC_STAGES > AngTabLen) ? AngTabLen : CORDIC_STAGES;

	// x, y in q2.30 fit 34 bits; z residual fits 34 bits
	logic signed [33:0] x_s [0:N];
	logic signed [33:0] y_s [0:N];
	logic signed [33:0] z_s [0:N];
	logic [1:0]         quad_s [0:N];

	always_comb begin
		x_s[0] = GainQ30;
		y_s[0] = '0;
		z_s[0] = {4'b0, angle[13:0], 16'b0};
		quad_s[0] = angle[15:14];
	end

	for (genvar i = 0; i < N; i++) begin : g_stage
		logic signed [33:0] dx, dy, t;
		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;
		assign t = {2'b0, atan_turns(5'(i))};
		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_s[i][33]) begin
					x_s[i+1] <= x_s[i] - dx;
					y_s[i+1] <= y_s[i] + dy;
					z_s[i+1] <= z_s[i] - t;
				end else begin
					x_s[i+1] <= x_s[i] + dx;
					y_s[i+1] <= y_s[i] - dy;
					z_s[i+1] <= z_s[i] + t;
				end
				quad_s[i+1] <= quad_s[i];
			end
		end
	end

	logic signed [15:0] cq, sq;
	logic signed [33:0] xr, yr;
	assign xr = (x_s[N] + 34'sd32768) >>> 16;
	assign yr = (y_s[N] + 34'sd32768) >>> 16;
	assign cq = clamp_q14(xr);
	assign sq = clamp_q14(yr);

	always_ff @(posedge clk) begin
		if (en) begin
			unique case (quad_s[N])
				2'd0: begin cos_q14 <= cq;  sin_q14 <= sq;  end
				2'd1: begin cos_q14 <= -sq; sin_q14 <= cq;  end
				2'd2: begin cos_q14 <= -cq; sin_q14 <= -sq; end
				default: begin cos_q14 <= sq; sin_q14 <= -cq; end
			endcase
		end
	end

endmodule

### src/rpy_matrix.sv
// module: product and rounding pipeline from six sines and cosines to nine q1.14 entries
`timescale 1ns / 1ps
module rpy_matrix (
	input  logic               clk,
	input  logic               en,
	input  logic signed [15:0] sr,
	input  logic signed [15:0] cr,
	input  logic signed [15:0] sp,
	input  logic signed [15:0] cp,
	input  logic signed [15:0] sy,
	input  logic signed [15:0] cy,
	output rpy_pkg::rpy_out_t  mat
);
	import rpy_pkg::*;

	// stage 1: pairwise products, q2.28
	logic signed [31:0] cpcy_s1, spsy_s1, cpsy_s1, spcy_s1;
	logic signed [31:0] crsy_s1, crcy_s1, crsp_s1, crcp_s1;
	logic signed [15:0] sr_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			cpcy_s1 <= cp * cy;
			spsy_s1 <= sp * sy;
			cpsy_s1 <= cp * sy;
			spcy_s1 <= sp * cy;
			crsy_s1 <= cr * sy;
			crcy_s1 <= cr * cy;
			crsp_s1 <= cr * sp;
			crcp_s1 <= cr * cp;
			sr_s1   <= sr;
		end
	end

	// stage 2: triple products at 42 fractional bits, double products shifted
	logic signed [47:0] t00_s2, t02_s2, t10_s2, t12_s2;
	logic signed [47:0] d00_s2, d02_s2, d10_s2, d12_s2;
	logic signed [47:0] d01_s2, d11_s2, d20_s2, d22_s2, d21_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			t00_s2 <= 48'(sr_s1) * 48'(spsy_s1);
			t02_s2 <= 48'(sr_s1) * 48'(cpsy_s1);
			t10_s2 <= 48'(sr_s1) * 48'(spcy_s1);
			t12_s2 <= 48'(sr_s1) * 48'(cpcy_s1);
			d00_s2 <= 48'(cpcy_s1) <<< 14;
			d02_s2 <= 48'(spcy_s1) <<< 14;
			d10_s2 <= 48'(cpsy_s1) <<< 14;
			d12_s2 <= 48'(spsy_s1) <<< 14;
			d01_s2 <= -(48'(crsy_s1) <<< 14);
			d11_s2 <= 48'(crcy_s1) <<< 14;
			d20_s2 <= -(48'(crsp_s1) <<< 14);
			d22_s2 <= 48'(crcp_s1) <<< 14;
			d21_s2 <= 48'(sr_s1) <<< 28;
		end
	end

	// stage 3: sum, round half up, saturate
	function automatic logic signed [15:0] to_entry(input logic signed [47:0] s);
		logic signed [47:0] r;
		r = (s + 48'sd134217728) >>> 28;
		return clamp_q14(r[33:0]);
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			mat.m00 <= to_entry(d00_s2 - t00_s2);
			mat.m01 <= to_entry(d01_s2);
			mat.m02 <= to_entry(d02_s2 + t02_s2);
			mat.m10 <= to_entry(d10_s2 + t10_s2);
			mat.m11 <= to_entry(d11_s2);
			mat.m12 <= to_entry(d12_s2 - t12_s2);
			mat.m20 <= to_entry(d20_s2);
			mat.m21 <= to_entry(d21_s2);
			mat.m22 <= to_entry(d22_s2);
		end
	end

endmodule

### src/rpy_to_rotation_matrix_unit.sv
// top level: roll/pitch/yaw to z-x-y rotation matrix, fully pipelined
`timescale 1ns / 1ps
// usage
//   in channel (in_valid/in_ready/in_data) carries one transaction of three
//   signed 16-bit binary angles; out channel (out_valid/out_ready/out_data)
//   carries the nine q1.14 matrix entries of Rz(yaw)*Rx(roll)*Ry(pitch)
// pipeline: CORDIC_STAGES cordic stages (capped at 24), one register for
//   quadrant fold, three for products, triple products and round/saturate
// throughput: one transaction per cycle unless stalled; the three parallel
//   cordics and the product stages take a new angle set every unstalled clock
// stall: the whole pipeline advances on one enable; when the output holds
//   an unaccepted transaction and out_ready is low, all stages freeze, so
//   nothing is lost or repeated; in_ready is high whenever the output
//   register is empty or being taken; bubbles inside the pipeline stay put
// reset: arst_n clears all valid bits; payload registers are not reset
module rpy_to_rotation_matrix_unit #(
	parameter int CORDIC_STAGES = rpy_pkg::CordicStagesDefault
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  rpy_pkg::rpy_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output rpy_pkg::rpy_out_t out_data
);
	import rpy_pkg::*;

	localparam int N = (CORDIC_STAGES > AngTabLen) ? AngTabLen : CORDIC_STAGES;
	// cordic stages + fold + three product stages
	localparam int Depth = N + 4;

	logic             en;
	logic [Depth-1:0] vld_q;

	// pipeline moves whenever the last slot is free or leaving
	assign en        = !vld_q[Depth-1] || out_ready;
	assign in_ready  = en;
	assign out_valid = vld_q[Depth-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[Depth-2:0], in_valid};
		end
	end

	logic signed [15:0] sr, cr, sp, cp, sy, cy;

	rpy_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_roll (
		.clk(clk), .en(en), .angle(in_data.roll_angle),
		.sin_q14(sr), .cos_q14(cr)
	);
	rpy_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_pitch (
		.clk(clk), .en(en), .angle(in_data.pitch_angle),
		.sin_q14(sp), .cos_q14(cp)
	);
	rpy_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_yaw (
		.clk(clk), .en(en), .angle(in_data.yaw_angle),
		.sin_q14(sy), .cos_q14(cy)
	);

	// products, sums and rounding
	rpy_matrix u_matrix (
		.clk(clk), .en(en),
		.sr(sr), .cr(cr), .sp(sp), .cp(cp), .sy(sy), .cy(cy),
		.mat(out_data)
	);

endmodule
